// File: sv/fnv_pkg.sv
// fnv_pkg: shared constants and types for the fnv-1a 64-bit hasher
// no dependencies; imported by every module of the block

package fnv_pkg;

	localparam int unsigned HASH_W   = 64;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned FOLDS_PER_WORD = HASH_W / BYTE_W;
	localparam int unsigned ADDR_W   = 4;
	localparam int unsigned CNT_W    = 3;

	localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

	// register index taken from paddr[3]
	localparam logic REG_SEED = 1'b0;

	// fold counter start value, one less than the folds still to do after the first one of a word
	localparam logic [CNT_W-1:0] CNT_WORD = CNT_W'(FOLDS_PER_WORD - 2);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} seq_state_t;

endpackage

// File: sv/fnv1a_64_byte_word_hasher.sv
// fnv1a_64_byte_word_hasher: running 64-bit fnv-1a digest over bytes or words
// depends on fnv_pkg, fnv_fold, fnv_apb
//
// Each input transaction folds either one byte (mode 0, data[7:0]) or one
// 64-bit word (mode 1, eight bytes, least significant first) into the running
// digest and returns the updated digest as one output transaction. With
// start_req set the digest restarts from the seed register (byte address 0,
// 64-bit apb data, reset value is the fnv-1a offset basis) before folding.
// A single fold unit (xor plus constant multiply by the fnv prime) does one
// byte per cycle under a small sequencer: the first byte is folded in the
// accept cycle, the remaining seven of a word in the following cycles, then
// the drain state hands the digest to the output register once that register
// is free; in_stall is high while the sequencer is busy. The output register
// lets the next transaction be accepted while a previous result is still
// stalled. The seed should only be written while the block is idle; a new
// seed is used by the next transaction with start_req set.

module fnv1a_64_byte_word_hasher (
	input  logic                       clk,
	input  logic                       arst_n,
	// input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       mode,
	input  logic [fnv_pkg::HASH_W-1:0] data,
	input  logic                       start_req,
	// output channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [fnv_pkg::HASH_W-1:0] hash_out,
	// apb configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fnv_pkg::ADDR_W-1:0] paddr,
	input  logic [fnv_pkg::HASH_W-1:0] pwdata,
	output logic [fnv_pkg::HASH_W-1:0] prdata,
	output logic                       pready
);
	import fnv_pkg::*;

	seq_state_t state_q, state_d;

	logic [HASH_W-1:0]        seed;
	logic [HASH_W-1:0]        acc_q;     // running digest, also the work register
	logic [HASH_W-BYTE_W-1:0] data_q;    // bytes of the word still to fold
	logic [CNT_W-1:0]         cnt_q;
	logic                     out_valid_q;
	logic [HASH_W-1:0]        hash_q;

	logic [HASH_W-1:0] fold_din;
	logic [BYTE_W-1:0] fold_byte;
	logic [HASH_W-1:0] fold_dout;
	logic              in_accept;
	logic              acc_en;
	logic              load_out;
	logic              out_free;

	// register slave, seed is index 0 at paddr[3] == 0
	fnv_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.reg_idx (paddr[3]),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.seed    (seed)
	);

	// the shared fold unit: in the accept cycle it takes the port data and
	// the chosen start digest, afterwards the shifted word and acc_q
	always_comb begin
		if (state_q == ST_IDLE) begin
			fold_din  = start_req ? seed : acc_q;
			fold_byte = data[BYTE_W-1:0];
		end else begin
			fold_din  = acc_q;
			fold_byte = data_q[BYTE_W-1:0];
		end
	end

	fnv_fold u_fold (
		.digest (fold_din),
		.octet  (fold_byte),
		.folded (fold_dout)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d  = state_q;
		acc_en   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					acc_en  = 1'b1;
					state_d = mode ? ST_RUN : ST_DRAIN;
				end
			end
			ST_RUN: begin
				acc_en = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// wait until the output register can take the digest
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// running digest survives between transactions, so it is reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= FNV_BASIS;
		end else if (acc_en) begin
			acc_q <= fold_dout;
		end
	end

	// byte shifter and fold counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_accept) begin
			cnt_q <= CNT_WORD;
		end else if (state_q == ST_RUN) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			data_q <= data[HASH_W-1:BYTE_W];
		end else if (state_q == ST_RUN) begin
			data_q <= {{BYTE_W{1'b0}}, data_q[HASH_W-BYTE_W-1:BYTE_W]};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			hash_q <= acc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hash_out  = hash_q;

endmodule

// File: sv/fnv_fold.sv
// fnv_fold: one fnv-1a byte fold, xor then multiply by the 64-bit prime
// depends on fnv_pkg

module fnv_fold (
	input  logic [fnv_pkg::HASH_W-1:0] digest,
	input  logic [fnv_pkg::BYTE_W-1:0] octet,
	output logic [fnv_pkg::HASH_W-1:0] folded
);
	import fnv_pkg::*;

	logic [HASH_W-1:0] x;

	assign x = digest ^ {{(HASH_W-BYTE_W){1'b0}}, octet};

	// prime = 2^40 + 0x1b3, 0x1b3 = bits 8,7,5,4,1,0
	assign folded = (x << 40) + (x << 8) + (x << 7) + (x << 5)
		+ (x << 4) + (x << 1) + x;

endmodule

// File: sv/fnv_apb.sv
// fnv_apb: apb register slave holding the seed register
// depends on fnv_pkg

module fnv_apb (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       reg_idx,
	input  logic [fnv_pkg::HASH_W-1:0] pwdata,
	output logic [fnv_pkg::HASH_W-1:0] prdata,
	output logic                       pready,
	output logic [fnv_pkg::HASH_W-1:0] seed
);
	import fnv_pkg::*;

	logic [HASH_W-1:0] seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= FNV_BASIS;
		end else if (psel && penable && pwrite && (reg_idx == REG_SEED)) begin
			seed_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (reg_idx == REG_SEED) ? seed_q : '0;
	assign seed   = seed_q;

endmodule

// File: sv/fnv_chk.sv
// fnv_chk: port-level checks for the fnv-1a hasher, bound to the top level
// depends on fnv_pkg and fnv1a_64_byte_word_hasher

module fnv_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       mode,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [fnv_pkg::HASH_W-1:0] hash_out
);
	import fnv_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// a stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hash_out))
		else $error("result changed while stalled");

	// the sequencer is busy in the cycle after a transaction is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on consecutive cycles");

	// a byte transaction taken while no result is offered goes through the drain state straight into the output register
	a_byte_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !mode && !out_valid |=> ##1 out_valid)
		else $error("byte result late");

endmodule

bind fnv1a_64_byte_word_hasher fnv_chk u_fnv_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.mode      (mode),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.hash_out  (hash_out)
);

// File: tb/fnv_hash_checker.sv
// fnv_hash_checker: watches the hasher's input, output and apb ports, predicts each digest
// depends on fnv_pkg; instantiated beside the block by tb_top

module fnv_hash_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       mode,
	input  logic [fnv_pkg::HASH_W-1:0] data,
	input  logic                       start_req,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [fnv_pkg::HASH_W-1:0] hash_out,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fnv_pkg::ADDR_W-1:0] paddr,
	input  logic [fnv_pkg::HASH_W-1:0] pwdata,
	input  logic [fnv_pkg::HASH_W-1:0] prdata,
	input  logic                       pready,
	output int                         fail_count,
	output int                         pending,
	output int                         checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import fnv_pkg::*;

	localparam logic [HASH_W-1:0] FNV_PRIME = 64'h0000_0100_0000_01B3;

	logic [HASH_W-1:0] seed_q;
	logic [HASH_W-1:0] digest_q;
	logic [HASH_W-1:0] digests_due[$];

	// xor-multiply over one byte, or over all eight bytes lsb first
	function automatic logic [HASH_W-1:0] fold_item(input logic [HASH_W-1:0] from,
			input logic word_mode, input logic [HASH_W-1:0] value);
		logic [HASH_W-1:0] d;
		int               n;
		d = from;
		n = word_mode ? FOLDS_PER_WORD : 1;
		for (int i = 0; i < n; i++)
			d = (d ^ HASH_W'(value[i*BYTE_W +: BYTE_W])) * FNV_PRIME;
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [HASH_W-1:0] want;
		int                errs;
		int                hits;
		if (!arst_n) begin
			seed_q = FNV_BASIS;
			digest_q = FNV_BASIS;
			digests_due.delete();
			fail_count <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			errs = 0;
			hits = 0;
			// results first: none can stem from an input taken at this edge
			if (out_valid && !out_stall) begin
				if (digests_due.size() == 0) begin
					$display("%0t: unexpected digest, expected none, actual %h",
						$time, hash_out);
					errs++;
				end else begin
					want = digests_due.pop_front();
					hits = 1;
					if (hash_out !== want) begin
						$display("%0t: hash_out mismatch, expected %h, actual %h",
							$time, want, hash_out);
						errs++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				digest_q = fold_item(start_req ? seed_q : digest_q, mode, data);
				digests_due.push_back(digest_q);
			end
			if (psel && penable && pready && paddr[3] == REG_SEED) begin
				if (pwrite)
					seed_q = pwdata;
				else if (prdata !== seed_q) begin
					$display("%0t: seed readback mismatch, expected %h, actual %h",
						$time, seed_q, prdata);
					errs++;
				end
			end
			fail_count <= fail_count + errs;
			checked <= checked + hits;
			pending <= digests_due.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// tb_top: stimulus and verdict for fnv1a_64_byte_word_hasher
// depends on fnv_pkg, the hasher rtl and fnv_hash_checker

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fnv_pkg::*;

	// byte addresses on the apb port: seed at 0, address 8 maps to no register
	localparam logic [ADDR_W-1:0] SEED_ADDR   = 4'h0;
	localparam logic [ADDR_W-1:0] UNUSED_ADDR = 4'h8;

	localparam int N_PHASES        = 8;
	localparam int ITEMS_PER_PHASE = 142;
	localparam int SETTLE_CYCLES   = 12;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 1500;

	localparam logic [HASH_W-1:0] ALL_ONES = '1;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic              mode      = 1'b0;
	logic [HASH_W-1:0] data      = '0;
	logic              start_req = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [HASH_W-1:0] hash_out;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [HASH_W-1:0] pwdata    = '0;
	logic [HASH_W-1:0] prdata;
	logic              pready;

	int fail_count;
	int pending;
	int checked;

	// idle limits per side, changed per phase
	int tx_max = 2;
	int rx_max = 2;
	// a nonzero value asks the receiver for one long hold-off
	int hold_cycles = 0;
	int n_sent = 0;
	int n_seeds = 0;

	// sender and receiver idle limits for each random phase
	int tx_lim[N_PHASES] = '{0, 10, 0, 10, 10, 3, 10, 0};
	int rx_lim[N_PHASES] = '{0, 10, 10, 0, 10, 3, 10, 0};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	fnv1a_64_byte_word_hasher DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.data      (data),
		.start_req (start_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hash_out  (hash_out),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	fnv_hash_checker digest_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.data       (data),
		.start_req  (start_req),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_out   (hash_out),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	// mostly full random words, now and then the extremes
	function automatic logic [HASH_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ALL_ONES;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// one input transaction: random gap, then hold valid until taken
	task automatic send_item(input logic m, input logic [HASH_W-1:0] d, input logic s);
		int gap;
		gap = $urandom_range(0, tx_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		data <= d;
		start_req <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_sent++;
	endtask

	// drop valid and wait until every digest has come out and the block is quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write, then a read of the same address, which the checker compares for the seed address
	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [HASH_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		// write has landed; set up the read-back
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (addr == SEED_ADDR)
			n_seeds++;
	endtask

	// receiver: random stall per result, plus one long hold-off on request
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			if (hold_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			k = $urandom_range(0, rx_max);
			if (k != 0) begin
				out_stall <= 1'b1;
				repeat (k) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// watchdog: ends the run when no transaction moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: timeout, nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [HASH_W-1:0] seed_val;
		logic              s;
		int                msg_left;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first transactions run from the reset digest with no seed write
		send_item(1'b0, 64'h0, 1'b0);
		// byte mode ignores everything above bit 7
		send_item(1'b0, 64'hFFFF_FFFF_FFFF_FF00, 1'b0);
		send_item(1'b0, ALL_ONES, 1'b0);
		send_item(1'b1, ALL_ONES, 1'b0);
		send_item(1'b1, 64'h0, 1'b0);
		send_item(1'b1, 64'h0123_4567_89AB_CDEF, 1'b0);
		send_item(1'b0, 64'h0000_0000_0000_0061, 1'b1);
		send_item(1'b1, rand_word(), 1'b1);
		send_item(1'b0, 64'h5555_5555_5555_55AA, 1'b1);
		settle();
		write_reg(SEED_ADDR, 64'h0);
		send_item(1'b0, 64'h0, 1'b1);
		send_item(1'b1, ALL_ONES, 1'b0);
		settle();
		// new seed mid-stream: running digest carries on until the next restart
		write_reg(SEED_ADDR, ALL_ONES);
		send_item(1'b0, 64'h0000_0000_0000_0080, 1'b0);
		send_item(1'b1, 64'h8000_0000_0000_0001, 1'b1);
		settle();
		// write to an address with no register behind it is dropped
		write_reg(UNUSED_ADDR, rand_word());
		send_item(1'b0, 64'h0000_0000_0000_00FF, 1'b1);
		settle();

		// random phases: messages open with a restart, with stray restarts as noise
		for (int phase = 0; phase < N_PHASES; phase++) begin
			case (phase)
				0, 7: seed_val = FNV_BASIS;
				1: seed_val = 64'h0;
				2: seed_val = ALL_ONES;
				4: seed_val = 64'h1;
				5: seed_val = 64'h8000_0000_0000_0000;
				default: seed_val = {$urandom(), $urandom()};
			endcase
			if (phase == 4)
				write_reg(UNUSED_ADDR, rand_word());
			write_reg(SEED_ADDR, seed_val);
			tx_max = tx_lim[phase];
			rx_max = rx_lim[phase];
			// long output hold while the sender keeps offering, so the block backs up
			if (phase == 2)
				hold_cycles = HOLD_CYCLES;
			msg_left = 0;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (msg_left == 0) begin
					s = 1'b1;
					msg_left = $urandom_range(1, 12);
				end else begin
					s = ($urandom_range(0, 15) == 0);
				end
				msg_left--;
				send_item(1'($urandom_range(0, 1)), rand_word(), s);
			end
			settle();
		end

		// end of stimulus: drain, then some quiet cycles
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d input transactions and %0d compared digests", n_sent, checked);
		$display("over %0d seed settings incl. zero, all ones and the basis, plus one long hold",
			n_seeds);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d failures, %0d digests outstanding", fail_count, pending);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
